FILE: design/dhcc_pkg.sv
// Package for the dual hook climb controller: codes, field types and the
// per-hook tracking and drive functions. No dependencies.
package dhcc_pkg;

  typedef logic [2:0] pos_t;
  typedef logic [1:0] dir_t;
  typedef logic [1:0] drive_t;
  typedef logic [1:0] vcmd_t;

  localparam pos_t POS_BOTTOM  = 3'd0;
  localparam pos_t POS_MIDLOW  = 3'd1;
  localparam pos_t POS_MIDHIGH = 3'd2;
  localparam pos_t POS_TOP     = 3'd3;
  localparam pos_t POS_UNKNOWN = 3'd4;

  localparam dir_t DIR_STOP = 2'd0;
  localparam dir_t DIR_UP   = 2'd1;
  localparam dir_t DIR_DOWN = 2'd2;
  localparam dir_t DIR_BAD  = 2'd3;

  localparam drive_t DRV_STOP = 2'b00;
  localparam drive_t DRV_UP   = 2'b01;
  localparam drive_t DRV_DOWN = 2'b11;
  localparam drive_t DRV_BAD  = 2'b10;

  localparam vcmd_t VCMD_OFF = 2'd0;
  localparam vcmd_t VCMD_BAD = 2'd3;

  localparam logic CFG_EXTEND_TICKS = 1'b0;
  localparam logic CFG_GRAB_TICKS   = 1'b1;

  localparam int TICKS_W = 16;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd60;

  localparam int IN_W  = 16;
  localparam int OUT_W = 24;

  // Position from switches (pressed = 1) and the direction of the last tick.
  function automatic pos_t track(pos_t pos, logic bot, logic top, logic mid, dir_t last_dir);
    pos_t r;
    r = pos;
    if (bot) begin
      r = POS_BOTTOM;
    end else if (top) begin
      r = POS_TOP;
    end else if (mid) begin
      if (last_dir == DIR_UP) begin
        r = POS_MIDLOW;
      end else if (last_dir == DIR_DOWN) begin
        r = POS_MIDHIGH;
      end
    end else if (last_dir == DIR_UP && pos == POS_MIDLOW) begin
      r = POS_MIDHIGH;
    end else if (last_dir == DIR_DOWN && pos == POS_MIDHIGH) begin
      r = POS_MIDLOW;
    end
    return r;
  endfunction

  function automatic drive_t drive(dir_t dir, pos_t pos, pos_t target, logic top, logic bot);
    logic known;
    drive_t r;
    known = (pos != POS_UNKNOWN) && (target != POS_UNKNOWN);
    r = DRV_STOP;
    if (dir == DIR_UP) begin
      if (!(top || (known && pos >= target))) r = DRV_UP;
    end else if (dir == DIR_DOWN) begin
      if (!(bot || (known && pos <= target))) r = DRV_DOWN;
    end
    return r;
  endfunction

endpackage

FILE: design/dual_hook_climb_controller.sv
// Top level of the dual hook climb controller: input word register, per-tick
// hook tracking and drive, two timed valves, result word register.
// Uses dhcc_pkg and dhcc_valve.

// One word per control tick, one tick accepted per clock cycle unless the result
// side stalls. A word passes an input register and a result register before its
// result is offered; the tracked hook positions, last direction and
// valve timers advance when a word moves into the result register. The input
// side keeps taking words while a result waits as long as the input register
// is free. Travel registers are written through cfg_we/cfg_addr/cfg_wdata
// (index 0 extend_ticks, index 1 grab_ticks, both reset to 60) and should be
// written only while no tick is in flight. TICK_BITS sets the width of the
// saturating valve travel counters.
module dual_hook_climb_controller import dhcc_pkg::*; #(
  parameter int TICK_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  // left_top_raw, right_top_raw, left_mid_raw, right_mid_raw, left_bot_raw,
  // right_bot_raw, hook_dir[1:0], stop_at[2:0], extender_cmd[1:0],
  // claw_cmd[1:0], zero pad
  input  logic [IN_W-1:0]    s_axis_tdata,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // left_drive[1:0], right_drive[1:0], hooks_settled, left_hook_pos[2:0],
  // right_hook_pos[2:0], extender_valve[1:0], claw_valve[1:0],
  // extender_state[1:0], claw_state[1:0], zero pad
  output logic [OUT_W-1:0]   m_axis_tdata,
  input  logic               cfg_we,
  input  logic               cfg_addr,
  input  logic [TICKS_W-1:0] cfg_wdata
);

  logic               in_valid;
  logic [IN_W-1:0]    in_word;
  logic               out_valid;
  logic [OUT_W-1:0]   out_word;
  logic               advance;

  logic [TICKS_W-1:0] extend_ticks;
  logic [TICKS_W-1:0] grab_ticks;

  pos_t left_pos, left_pos_next;
  pos_t right_pos, right_pos_next;
  dir_t last_dir, dir;
  pos_t target;
  logic lt, rt, lm, rm, lb, rb;
  drive_t left_drive, right_drive;
  logic   hooks_settled;
  vcmd_t  ext_valve, claw_valve, ext_state, claw_state;
  logic [OUT_W-1:0] out_word_next;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_word;

  always_ff @(posedge clk) begin
    if (rst) begin
      extend_ticks <= TICKS_RESET;
      grab_ticks   <= TICKS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_EXTEND_TICKS: extend_ticks <= cfg_wdata;
        CFG_GRAB_TICKS:   grab_ticks   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Switches are active low
  always_comb begin
    lt     = !in_word[0];
    rt     = !in_word[1];
    lm     = !in_word[2];
    rm     = !in_word[3];
    lb     = !in_word[4];
    rb     = !in_word[5];
    dir    = (in_word[7:6] == DIR_BAD) ? DIR_STOP : in_word[7:6];
    target = (in_word[10:8] > POS_UNKNOWN) ? POS_UNKNOWN : in_word[10:8];

    left_pos_next  = track(left_pos, lb, lt, lm, last_dir);
    right_pos_next = track(right_pos, rb, rt, rm, last_dir);
    left_drive     = drive(dir, left_pos_next, target, lt, lb);
    right_drive    = drive(dir, right_pos_next, target, rt, rb);
    hooks_settled  = (left_drive == DRV_STOP) && (right_drive == DRV_STOP);

    out_word_next = {5'd0, claw_state, ext_state, claw_valve, ext_valve,
                     right_pos_next, left_pos_next, hooks_settled,
                     right_drive, left_drive};
  end

  dhcc_valve #(.TICK_BITS(TICK_BITS)) u_ext_valve (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .cmd     (in_word[12:11]),
    .ticks   (extend_ticks),
    .cmd_out (ext_valve),
    .state   (ext_state)
  );

  dhcc_valve #(.TICK_BITS(TICK_BITS)) u_claw_valve (
    .clk     (clk),
    .rst     (rst),
    .en      (advance),
    .cmd     (in_word[14:13]),
    .ticks   (grab_ticks),
    .cmd_out (claw_valve),
    .state   (claw_state)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
      left_pos  <= POS_UNKNOWN;
      right_pos <= POS_UNKNOWN;
      last_dir  <= DIR_STOP;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid <= 1'b1;
      end else if (advance) begin
        in_valid <= 1'b0;
      end
      if (advance) begin
        out_valid <= 1'b1;
        left_pos  <= left_pos_next;
        right_pos <= right_pos_next;
        last_dir  <= dir;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) in_word <= s_axis_tdata;
    if (advance) out_word <= out_word_next;
  end

`ifndef SYNTH
  a_settled: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_word[4] == ((out_word[1:0] == DRV_STOP) && (out_word[3:2] == DRV_STOP)))
    else $error("settled flag disagrees with drives");

  a_drive_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word[1:0] != DRV_BAD) && (out_word[3:2] != DRV_BAD))
    else $error("illegal drive code");

  // A stalled result keeps the pending tick in the input register
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    in_valid && out_valid && !m_axis_tready |=> in_valid && $stable(in_word))
    else $error("pending tick lost while result stalled");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(left_pos) && $stable(right_pos) && $stable(last_dir))
    else $error("hook state changed without a tick");
`endif

endmodule

FILE: design/dhcc_valve.sv
// Timed pneumatic valve: holds the commanded position and a travel counter,
// reports off until the travel time has passed. Uses dhcc_pkg.
module dhcc_valve import dhcc_pkg::*; #(
  parameter int TICK_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  vcmd_t              cmd,
  input  logic [TICKS_W-1:0] ticks,
  output vcmd_t              cmd_out,
  output vcmd_t              state
);

  localparam int CW = (TICK_BITS > TICKS_W) ? TICK_BITS : TICKS_W;

  vcmd_t                pos, pos_next;
  logic                 moving, moving_next;
  logic [TICK_BITS-1:0] count, count_next;
  logic                 moving_set;

  always_comb begin
    cmd_out     = (cmd == VCMD_BAD) ? VCMD_OFF : cmd;
    pos_next    = pos;
    moving_set  = moving;
    count_next  = count;
    if (cmd_out != pos) begin
      pos_next   = cmd_out;
      moving_set = 1'b1;
      count_next = '0;
    end else if (moving && count != {TICK_BITS{1'b1}}) begin
      count_next = count + 1'b1;
    end
    moving_next = moving_set && (CW'(count_next) < CW'(ticks));
    state       = moving_next ? VCMD_OFF : pos_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= VCMD_OFF;
      moving <= 1'b0;
      count  <= '0;
    end else if (en) begin
      pos    <= pos_next;
      moving <= moving_next;
      count  <= count_next;
    end
  end

`ifndef SYNTH
  // A command change restarts the travel counter
  a_restart: assert property (@(posedge clk) disable iff (rst)
    en && (cmd_out != pos) |=> (count == '0) && (pos == $past(cmd_out)))
    else $error("valve counter not restarted on command change");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(pos) && $stable(moving) && $stable(count))
    else $error("valve state changed without a tick");

  // Settled valve reports the held position
  a_report: assert property (@(posedge clk) disable iff (rst)
    en && !moving && (cmd_out == pos) |-> state == pos)
    else $error("settled valve reports wrong state");
`endif

endmodule
